### design/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared defaults and the status record passed from the remainder unit to
// the sequencer.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Default width of the number under test.
  localparam int NUMBER_BITS_DEF = 24;

  // Status of the shared remainder unit, valid in the cycle done is high.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_status_t;

endpackage

### design/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// Trial division prime test
// Operation: candidates below 4 are decided with no trial divisor; otherwise
//   the divisors from 2 up to floor(sqrt(n)) are tried in turn (at most
//   floor(sqrt(n)) - 1 of them), stopping at the first that leaves remainder
//   zero. Each try is one run of the shared remainder unit, one bit per cycle.
// Throughput: one item at a time; busy stays high until the result strobe,
//   and the receiver cannot stall the result.
// Reset: synchronous and active high; clears the sequencer and the strobe.
// ----------------------------------------------------------------------------
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUMBER_BITS-1:0] candidate,
  output logic                   busy,
  output logic                   valid,
  output logic                   is_prime
);

  logic                   unit_start;
  logic [NUMBER_BITS-1:0] dividend;
  logic [NUMBER_BITS-1:0] divisor;
  rem_status_t            unit_status;

  // Sequencer over the trial divisors.
  tdpt_ctrl #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .candidate  (candidate),
    .busy       (busy),
    .valid      (valid),
    .is_prime   (is_prime),
    .unit_start (unit_start),
    .dividend   (dividend),
    .divisor    (divisor),
    .unit_status(unit_status)
  );

  // Shared remainder unit.
  tdpt_rem_unit #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .dividend(dividend),
    .divisor (divisor),
    .status  (unit_status)
  );

  // A result is only given once the item has been worked on, and frees the block.
  assert property (@(posedge clk) disable iff (rst) valid |-> ($past(busy) && !busy))
    else $error("result strobe without a preceding busy period");

  // An accepted item always makes the block busy.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // The remainder unit only reports while an item is being tested.
  assert property (@(posedge clk) disable iff (rst) unit_status.done |-> busy)
    else $error("remainder unit finished while idle");

  // A divisor is never launched in the same cycle as a result.
  assert property (@(posedge clk) disable iff (rst) !(unit_start && valid))
    else $error("divisor launched alongside a result");

endmodule

### design/tdpt_rem_unit.sv
// ----------------------------------------------------------------------------
// Trial division remainder unit
// Restoring shift-and-subtract unit that forms dividend mod divisor, one
// dividend bit per cycle, and reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdpt_rem_unit import tdpt_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUMBER_BITS-1:0] dividend,
  input  logic [NUMBER_BITS-1:0] divisor,
  output rem_status_t            status
);

  localparam int CntW = $clog2(NUMBER_BITS + 1);

  logic                   run;
  logic                   done;
  logic [CntW-1:0]        cnt;
  logic [NUMBER_BITS-1:0] rem;
  logic [NUMBER_BITS-1:0] shift;
  logic [NUMBER_BITS-1:0] dvsr;
  logic [NUMBER_BITS:0]   trial;
  logic [NUMBER_BITS:0]   dvsr_ext;

  // Bring down the next dividend bit beside the partial remainder.
  assign trial    = {rem, shift[NUMBER_BITS-1]};
  assign dvsr_ext = {1'b0, dvsr};

  // Control: run until every dividend bit has been brought down, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CntW'(NUMBER_BITS);
      end else if (run) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract the divisor whenever it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shift <= dividend;
      dvsr  <= divisor;
    end else if (run) begin
      shift <= {shift[NUMBER_BITS-2:0], 1'b0};
      if (trial >= dvsr_ext) begin
        rem <= NUMBER_BITS'(trial - dvsr_ext);
      end else begin
        rem <= trial[NUMBER_BITS-1:0];
      end
    end
  end

  assign status.done     = done;
  assign status.rem_zero = (rem == '0);

endmodule

### design/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// Trial division sequencer
// Steps the trial divisor from two upward while its square does not exceed
// the candidate and no divisor has divided it, hands each divisor to the
// remainder unit and issues the verdict.
// ----------------------------------------------------------------------------
module tdpt_ctrl import tdpt_pkg::*; #(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUMBER_BITS-1:0] candidate,
  output logic                   busy,
  output logic                   valid,
  output logic                   is_prime,
  output logic                   unit_start,
  output logic [NUMBER_BITS-1:0] dividend,
  output logic [NUMBER_BITS-1:0] divisor,
  input  rem_status_t            unit_status
);

  localparam int SqW = NUMBER_BITS + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]             state;
  logic [NUMBER_BITS-1:0] value;
  logic [NUMBER_BITS-1:0] div_cnt;
  logic [SqW-1:0]         square;
  logic [SqW-1:0]         value_ext;

  assign value_ext = {2'b00, value};
  assign busy      = (state != ST_IDLE);
  assign dividend  = value;
  assign divisor   = div_cnt;

  // Sequencer: check the bound, run one remainder, then move to the next divisor.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= 1'b0;
      unit_start <= 1'b0;
    end else begin
      valid      <= 1'b0;
      unit_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (value < NUMBER_BITS'(2)) begin
            valid <= 1'b1;
            state <= ST_IDLE;
          end else if (square > value_ext) begin
            valid <= 1'b1;
            state <= ST_IDLE;
          end else begin
            unit_start <= 1'b1;
            state      <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (unit_status.done) begin
            if (unit_status.rem_zero) begin
              valid <= 1'b1;
              state <= ST_IDLE;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload: candidate, divisor and its square kept as a running sum.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          value   <= candidate;
          div_cnt <= NUMBER_BITS'(2);
          square  <= SqW'(4);
        end
      end
      ST_CHECK: begin
        if (value < NUMBER_BITS'(2)) begin
          is_prime <= 1'b0;
        end else if (square > value_ext) begin
          is_prime <= 1'b1;
        end
      end
      ST_WAIT: begin
        if (unit_status.done) begin
          if (unit_status.rem_zero) begin
            is_prime <= 1'b0;
          end else begin
            // (d + 1)^2 = d^2 + 2d + 1
            square  <= square + {1'b0, div_cnt, 1'b0} + SqW'(1);
            div_cnt <= div_cnt + NUMBER_BITS'(1);
          end
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

### verif/tb_trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// Trial division prime test - testbench
// Sends candidates through the start/busy handshake and checks each is_prime
// strobe against a trial-division predictor kept in the testbench. Directed
// tests cover the small numbers, the field extremes and squares of primes.
// Random tests follow, with short gaps on the sending side, and the run ends
// with a burst of back-to-back items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trial_division_prime_test import tdpt_pkg::*; ();

  localparam int NB = NUMBER_BITS_DEF;
  // An item can try about 4096 trial divisors; the limit leaves room for
  // several times the longest item on every item sent.
  localparam longint unsigned CYCLE_LIMIT = 64000000;
  localparam int DRAIN_CYCLES = 16;

  // One expected verdict, kept with its candidate for the mismatch line.
  typedef struct {
    logic [NB-1:0] number;
    bit            prime;
  } verdict_t;

  logic          clk;
  logic          rst;
  logic          start;
  logic [NB-1:0] candidate;
  logic          busy;
  logic          valid;
  logic          is_prime;

  verdict_t        pending_verdicts[$];
  int unsigned     mismatch_count = 0;
  longint unsigned cycle_count = 0;
  bit              gaps_enabled;

  trial_division_prime_test #(
    .NUMBER_BITS(NB)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .candidate(candidate),
    .busy     (busy),
    .valid    (valid),
    .is_prime (is_prime)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Numbers below two are not prime; otherwise try each divisor up to the root.
  function automatic bit prime_by_division(input logic [NB-1:0] n);
    longint unsigned v;
    longint unsigned d;
    v = n;
    if (v < 2) return 1'b0;
    for (d = 2; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Offers one candidate and returns at the edge where the block takes it.
  // An optional idle gap of random length goes in front of the item.
  task automatic send_candidate(input logic [NB-1:0] value);
    verdict_t v;
    bit       taken;
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start     <= 1'b1;
    candidate <= value;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    v.number = value;
    v.prime  = prime_by_division(value);
    pending_verdicts = {pending_verdicts, v};
  endtask

  // Zero and one are not prime; two and three are prime with no divisor tried.
  task automatic test_small_numbers();
    int n;
    for (n = 0; n <= 5; n++) send_candidate(NB'(n));
    send_candidate(NB'(97));
  endtask

  // Extremes of the field and the alternating bit patterns.
  task automatic test_field_extremes();
    send_candidate({NB{1'b1}});
    send_candidate(NB'(24'd16777213));   // largest prime in 24 bits, longest run
    send_candidate(NB'(24'h800000));
    send_candidate(NB'(24'hAAAAAA));
    send_candidate(NB'(24'h555555));
    send_candidate(NB'(65521));
    send_candidate(NB'(65536));
    send_candidate(NB'(4096));
    send_candidate(NB'(4093));
  endtask

  // Squares of primes sit exactly on the d * d <= n bound.
  task automatic test_prime_squares();
    send_candidate(NB'(9));
    send_candidate(NB'(25));
    send_candidate(NB'(49));
    send_candidate(NB'(121));
    send_candidate(NB'(120));
    send_candidate(NB'(4093 * 4093));
  endtask

  // Random candidates, mostly small so that the run stays short, with squares
  // and their neighbours, products of two factors and a few full-width values.
  task automatic test_random_candidates(input int count);
    int unsigned   kind;
    int unsigned   a;
    int unsigned   b;
    logic [NB-1:0] value;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        value = NB'($urandom_range(0, 4095));
      end else if (kind < 70) begin
        a = $urandom_range(2, 255);
        value = NB'(a * a + $urandom_range(0, 2) - 1);
      end else if (kind < 85) begin
        value = NB'($urandom_range(0, 65535));
      end else if (kind < 95) begin
        a = $urandom_range(2, 4095);
        b = $urandom_range(2, 4095);
        value = NB'(a * b);
      end else begin
        value = NB'($urandom);
      end
      send_candidate(value);
    end
  endtask

  // Checks each result strobe against the oldest expected verdict.
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && valid) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result is_prime=%0b with no item pending", is_prime));
      end else begin
        v = pending_verdicts.pop_front();
        if (is_prime !== v.prime)
          report_mismatch($sformatf("candidate %0d: is_prime=%0b, expected %0b",
                                    v.number, is_prime, v.prime));
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    gaps_enabled = 1'b0;
    rst       <= 1'b1;
    start     <= 1'b0;
    candidate <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_small_numbers();
    gaps_enabled = 1'b1;
    test_field_extremes();
    test_prime_squares();
    test_random_candidates(100);
    // The closing stretch runs with no gaps at all.
    gaps_enabled = 1'b0;
    test_random_candidates(20);
    start <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
